@@ src/pwm_pin_channel_allocator_unit_macros.svh @@
// Assertion macros used by the allocator RTL.
`ifndef PWM_PIN_CHANNEL_ALLOCATOR_UNIT_MACROS_SVH
`define PWM_PIN_CHANNEL_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWMA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PWMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pwma_pkg.sv @@
`timescale 1ns / 1ps
package pwma_pkg;

	localparam int PIN_COUNT     = 54;
	localparam int CHANNEL_COUNT = 11;
	localparam int PIN_W         = 6;
	localparam int MASK_W        = 11;
	localparam int CH_W          = 4;
	localparam int TABLE_DEPTH   = 64;

	// Channels at or above CHANNEL_COUNT are never granted.
	localparam logic [MASK_W-1:0] CHAN_LIMIT = MASK_W'((32'd1 << CHANNEL_COUNT) - 32'd1);

	typedef enum logic [1:0] {
		ST_GRANT   = 2'd0,
		ST_BAD_PIN = 2'd1,
		ST_NO_FREE = 2'd2
	} pwma_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PICK,
		S_WALK,
		S_DONE
	} pwma_state_t;

	// Usable channel masks, one row per pin. Rows past the last pin are empty.
	localparam logic [MASK_W-1:0] PIN_MASKS [TABLE_DEPTH] = '{
		11'h01F, 11'h01F, 11'h03F, 11'h03F, 11'h07F, 11'h07F, 11'h070, 11'h070,
		11'h070, 11'h070, 11'h070, 11'h070, 11'h070, 11'h070, 11'h070, 11'h07F,
		11'h0FF, 11'h0FF, 11'h1FF, 11'h1FF, 11'h3F0, 11'h3F0, 11'h7F0, 11'h7F0,
		11'h7F0, 11'h7F0, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF,
		11'h7E0, 11'h7EF, 11'h7EF, 11'h7EF, 11'h78F, 11'h78F, 11'h78F, 11'h78F,
		11'h78F, 11'h78F, 11'h78F, 11'h78F, 11'h78F, 11'h78F, 11'h78F, 11'h78F,
		11'h700, 11'h700, 11'h600, 11'h600, 11'h400, 11'h400, 11'h000, 11'h000,
		11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000
	};

	function automatic logic [4:0] route_base(input logic [CH_W-1:0] ch);
		logic [4:0] base;
		case (ch)
			4'd1:    base = 5'd31;
			4'd2:    base = 5'd30;
			4'd3:    base = 5'd29;
			default: base = 5'd0;
		endcase
		return base;
	endfunction

endpackage

@@ src/pwm_pin_channel_allocator_unit.sv @@
// A request word is accepted in idle; the controller then reads the pin's mask row through the
// registered table port, picks the lowest free channel and, for a grant, walks the mask table
// over the lower pins, one row per cycle, before the result word is registered. An invalid pin
// skips the table; a pin with no free channel, or pin 0, skips the walk. A new request is taken
// only after the last result word is registered, and a stalled result word holds it off until taken.
// Reset clears the busy channel set, returns the controller to idle and empties the output.
`timescale 1ns / 1ps
`include "pwm_pin_channel_allocator_unit_macros.svh"
module pwm_pin_channel_allocator_unit
	import pwma_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [PIN_W-1:0] pin_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [CH_W-1:0]  global_channel,
	output logic [1:0]       timer_select,
	output logic [1:0]       timer_channel,
	output logic [2:0]       pad_port,
	output logic [3:0]       pad_pin,
	output logic [4:0]       route_location
);

	pwma_state_t       state_q, state_nxt;
	logic [MASK_W-1:0] busy_q;
	logic              out_valid_q;

	logic [PIN_W-1:0]  p_q;
	logic [PIN_W-1:0]  cnt_q;
	logic [CH_W-1:0]   ch_q;
	logic [4:0]        loc_q;
	pwma_status_t      status_q;

	logic [1:0]        out_status_q;
	logic [CH_W-1:0]   out_chan_q;
	logic [1:0]        out_timer_q;
	logic [1:0]        out_tchan_q;
	logic [2:0]        out_port_q;
	logic [3:0]        out_pin_q;
	logic [4:0]        out_loc_q;

	logic [PIN_W-1:0]  rom_addr;
	logic [MASK_W-1:0] rom_data;
	logic [MASK_W-1:0] free;
	logic [CH_W-1:0]   pick;
	logic              bad_pin;
	logic              out_free;
	logic [PIN_W-1:0]  cnt_inc;
	logic              row_hit;

	logic [2:0]        port_c;
	logic [PIN_W-1:0]  pin_c;
	logic [1:0]        timer_c;
	logic [CH_W-1:0]   tchan_c;

	pwma_mask_rom u_rom (
		.clk     (clk),
		.addr    (rom_addr),
		.rd_data (rom_data)
	);

	assign bad_pin  = {1'b0, pin_index} >= (PIN_W + 1)'(PIN_COUNT);
	assign out_free = !out_valid_q || !out_stall;
	assign cnt_inc  = PIN_W'(cnt_q + PIN_W'(1));
	assign free     = rom_data & ~busy_q & CHAN_LIMIT;
	assign row_hit  = |(rom_data & (MASK_W'(1) << ch_q));

	// Lowest free usable channel.
	always_comb begin
		pick = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (free[i]) begin
				pick = CH_W'(i);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		rom_addr  = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				rom_addr = pin_index;
				if (in_valid) begin
					state_nxt = bad_pin ? S_DONE : S_PICK;
				end
			end
			S_PICK: begin
				if (free == '0 || p_q == '0) begin
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_WALK;
				end
			end
			S_WALK: begin
				rom_addr = cnt_inc;
				if (cnt_inc == p_q) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_PICK && free != '0) begin
				busy_q <= busy_q | (MASK_W'(1) << pick);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Port and pin of the requested pin; the last row lands on port F, pin 13.
	always_comb begin
		if (p_q < PIN_W'(10)) begin
			port_c = 3'd0;
			pin_c  = p_q;
		end else if (p_q < PIN_W'(20)) begin
			port_c = 3'd1;
			pin_c  = PIN_W'(p_q - PIN_W'(4));
		end else if (p_q < PIN_W'(32)) begin
			port_c = 3'd2;
			pin_c  = PIN_W'(p_q - PIN_W'(20));
		end else if (p_q < PIN_W'(40)) begin
			port_c = 3'd3;
			pin_c  = PIN_W'(p_q - PIN_W'(24));
		end else begin
			port_c = 3'd4;
			pin_c  = PIN_W'(p_q - PIN_W'(40));
		end
	end

	always_comb begin
		if (ch_q < CH_W'(4)) begin
			timer_c = 2'd0;
			tchan_c = ch_q;
		end else if (ch_q < CH_W'(7)) begin
			timer_c = 2'd1;
			tchan_c = CH_W'(ch_q - CH_W'(4));
		end else begin
			timer_c = 2'd2;
			tchan_c = CH_W'(ch_q - CH_W'(7));
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				p_q      <= pin_index;
				status_q <= ST_BAD_PIN;
			end
			S_PICK: begin
				status_q <= (free == '0) ? ST_NO_FREE : ST_GRANT;
				ch_q     <= pick;
				loc_q    <= route_base(pick);
				cnt_q    <= '0;
			end
			S_WALK: begin
				// The route location wraps at 32 by plain overflow.
				if (row_hit) begin
					loc_q <= 5'(loc_q + 5'd1);
				end
				cnt_q <= cnt_inc;
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q <= status_q;
					if (status_q == ST_GRANT) begin
						out_chan_q  <= ch_q;
						out_timer_q <= timer_c;
						out_tchan_q <= tchan_c[1:0];
						out_port_q  <= port_c;
						out_pin_q   <= pin_c[3:0];
						out_loc_q   <= loc_q;
					end else begin
						out_chan_q  <= '0;
						out_timer_q <= '0;
						out_tchan_q <= '0;
						out_port_q  <= '0;
						out_pin_q   <= '0;
						out_loc_q   <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign global_channel = out_chan_q;
	assign timer_select   = out_timer_q;
	assign timer_channel  = out_tchan_q;
	assign pad_port       = out_port_q;
	assign pad_pin        = out_pin_q;
	assign route_location = out_loc_q;

	`PWMA_ASSERT_NEXT(a_busy_hold, clk, arst_n, state_q != S_PICK, busy_q == $past(busy_q), "busy set changed outside the pick step")
	`PWMA_ASSERT_NEXT(a_one_grant, clk, arst_n, state_q == S_PICK && free != '0, $countones(busy_q) == $countones($past(busy_q)) + 1, "grant did not mark exactly one channel")
	`PWMA_ASSERT_SAME(a_grant_busy, clk, arst_n, out_valid && status == ST_GRANT, ((busy_q >> global_channel) & MASK_W'(1)) != '0, "granted channel is not marked busy")
	`PWMA_ASSERT_SAME(a_walk_range, clk, arst_n, state_q == S_WALK, cnt_q < p_q, "table walk ran past the requested pin")

endmodule

@@ src/pwma_mask_rom.sv @@
`timescale 1ns / 1ps
module pwma_mask_rom
	import pwma_pkg::*;
(
	input  logic              clk,
	input  logic [PIN_W-1:0]  addr,
	output logic [MASK_W-1:0] rd_data
);

	logic [MASK_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		rd_data_q <= PIN_MASKS[addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ sim/pwm_pin_channel_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
module pwm_pin_channel_allocator_unit_tb;
	import pwma_pkg::*;

	localparam int RANDOM_WORDS = 1500;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 64;

	localparam logic [2:0] PORT_A = 3'd0;
	localparam logic [2:0] PORT_B = 3'd1;
	localparam logic [2:0] PORT_C = 3'd2;
	localparam logic [2:0] PORT_D = 3'd3;
	localparam logic [2:0] PORT_F = 3'd4;

	localparam logic [1:0] TMR_STD    = 2'd0;
	localparam logic [1:0] TMR_WIDE_A = 2'd1;
	localparam logic [1:0] TMR_WIDE_B = 2'd2;

	// Usable channels per pin; rows past the last pin are empty.
	localparam logic [MASK_W-1:0] USABLE [64] = '{
		11'h01F, 11'h01F, 11'h03F, 11'h03F, 11'h07F, 11'h07F, 11'h070, 11'h070,
		11'h070, 11'h070, 11'h070, 11'h070, 11'h070, 11'h070, 11'h070, 11'h07F,
		11'h0FF, 11'h0FF, 11'h1FF, 11'h1FF, 11'h3F0, 11'h3F0, 11'h7F0, 11'h7F0,
		11'h7F0, 11'h7F0, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF,
		11'h7E0, 11'h7EF, 11'h7EF, 11'h7EF, 11'h78F, 11'h78F, 11'h78F, 11'h78F,
		11'h78F, 11'h78F, 11'h78F, 11'h78F, 11'h78F, 11'h78F, 11'h78F, 11'h78F,
		11'h700, 11'h700, 11'h600, 11'h600, 11'h400, 11'h400, 11'h000, 11'h000,
		11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000
	};

	typedef struct packed {
		pwma_status_t    status;
		logic [CH_W-1:0] chan;
		logic [1:0]      tsel;
		logic [1:0]      tchan;
		logic [2:0]      port;
		logic [3:0]      pin;
		logic [4:0]      loc;
	} alloc_word_t;

	class alloc_scoreboard;
		logic [MASK_W-1:0] busy;
		alloc_word_t       grants_due[$];
		int                errors;

		function new();
			busy   = '0;
			errors = 0;
		endfunction

		function logic [4:0] loc_base(int ch);
			logic [4:0] b;
			case (ch)
				1:       b = 5'd31;
				2:       b = 5'd30;
				3:       b = 5'd29;
				default: b = 5'd0;
			endcase
			return b;
		endfunction

		// Predicts the word for an accepted request and updates the busy set.
		function void note_request(logic [PIN_W-1:0] p);
			alloc_word_t       w;
			logic [MASK_W-1:0] avail;
			int                ch;
			int                loc;
			w  = '0;
			ch = -1;
			if (p >= PIN_COUNT) begin
				w.status = ST_BAD_PIN;
			end else begin
				avail = USABLE[p] & ~busy;
				for (int i = CHANNEL_COUNT - 1; i >= 0; i--)
					if (avail[i])
						ch = i;
				if (ch < 0) begin
					w.status = ST_NO_FREE;
				end else begin
					busy[ch] = 1'b1;
					w.status = ST_GRANT;
					w.chan   = CH_W'(ch);
					if (ch < 4) begin
						w.tsel  = TMR_STD;
						w.tchan = 2'(ch);
					end else if (ch < 7) begin
						w.tsel  = TMR_WIDE_A;
						w.tchan = 2'(ch - 4);
					end else begin
						w.tsel  = TMR_WIDE_B;
						w.tchan = 2'(ch - 7);
					end
					// Each lower pin that can reach this channel moves the location by one.
					loc = loc_base(ch);
					for (int i = 0; i < p; i++)
						if (USABLE[i][ch])
							loc = (loc + 1) % 32;
					w.loc = 5'(loc);
					if (p < 10) begin
						w.port = PORT_A;
						w.pin  = 4'(p);
					end else if (p < 20) begin
						w.port = PORT_B;
						w.pin  = 4'(p - 4);
					end else if (p < 32) begin
						w.port = PORT_C;
						w.pin  = 4'(p - 20);
					end else if (p < 40) begin
						w.port = PORT_D;
						w.pin  = 4'(p - 24);
					end else begin
						w.port = PORT_F;
						w.pin  = 4'(p - 40);
					end
				end
			end
			grants_due.push_back(w);
		endfunction

		function void compare_field(string name, int exp_v, int got_v);
			if (exp_v != got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_word(alloc_word_t got);
			alloc_word_t exp_w;
			if (grants_due.size() == 0) begin
				$error("result word with no request outstanding");
				errors++;
				return;
			end
			exp_w = grants_due.pop_front();
			compare_field("status", exp_w.status, got.status);
			compare_field("global_channel", exp_w.chan, got.chan);
			compare_field("timer_select", exp_w.tsel, got.tsel);
			compare_field("timer_channel", exp_w.tchan, got.tchan);
			compare_field("pad_port", exp_w.port, got.port);
			compare_field("pad_pin", exp_w.pin, got.pin);
			compare_field("route_location", exp_w.loc, got.loc);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [PIN_W-1:0] pin_index;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       status;
	logic [CH_W-1:0]  global_channel;
	logic [1:0]       timer_select;
	logic [1:0]       timer_channel;
	logic [2:0]       pad_port;
	logic [3:0]       pad_pin;
	logic [4:0]       route_location;

	alloc_scoreboard sb = new();
	bit              hold_req = 1'b0;
	int              cycles = 0;

	// Walks every channel to exhaustion, with the bad-index and last-pin cases up front.
	logic [PIN_W-1:0] first_pins [20] = '{
		6'd63, 6'd54, 6'd53, 6'd0, 6'd0, 6'd52, 6'd50, 6'd48, 6'd20, 6'd33,
		6'd36, 6'd17, 6'd15, 6'd31, 6'd31, 6'd9, 6'd40, 6'd10, 6'd32, 6'd21
	};

	pwm_pin_channel_allocator_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pin_index      (pin_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.global_channel (global_channel),
		.timer_select   (timer_select),
		.timer_channel  (timer_channel),
		.pad_port       (pad_port),
		.pad_pin        (pad_pin),
		.route_location (route_location)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("pwm_pin_channel_allocator_unit test failed");
			$finish;
		end
	end

	always @(posedge clk) begin : result_monitor
		alloc_word_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = pwma_status_t'(status);
			got.chan   = global_channel;
			got.tsel   = timer_select;
			got.tchan  = timer_channel;
			got.port   = pad_port;
			got.pin    = pad_pin;
			got.loc    = route_location;
			sb.check_word(got);
		end
	end

	// Receiver: random stall modes of random length, plus one long hold-off on request.
	initial begin
		int stall_mode;
		int mode_left;
		stall_mode = 0;
		mode_left  = 0;
		out_stall  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 120);
			end
			mode_left--;
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= 1'($urandom_range(0, 1));
				2:       out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic send_pin(input logic [PIN_W-1:0] p);
		in_valid  <= 1'b1;
		pin_index <= p;
		do @(posedge clk); while (in_stall);
		sb.note_request(p);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			in_valid  <= 1'b0;
			pin_index <= PIN_W'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_all_words();
		while (sb.grants_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int sent;
		int burst;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pin_index = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (first_pins[i]) begin
			send_pin(first_pins[i]);
			idle_for($urandom_range(0, 3));
		end

		// Long receiver hold-off while the sender keeps offering words.
		hold_req = 1'b1;
		for (int k = 0; k < 10; k++)
			send_pin(PIN_W'($urandom_range(0, 63)));
		idle_for(1);
		wait_all_words();

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 16);
			for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
				send_pin(PIN_W'($urandom_range(0, 63)));
				sent++;
			end
			idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
		end
		in_valid <= 1'b0;

		wait_all_words();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.grants_due.size() == 0)
			$display("pwm_pin_channel_allocator_unit test passed");
		else
			$display("pwm_pin_channel_allocator_unit test failed");
		$finish;
	end

endmodule
